@@ hw/rtl/srd_pkg.sv @@
// Shared types, byte codes and the unescape helper for the slipmux receive demultiplexer.
package srd_pkg;

  localparam logic [7:0] END_BYTE       = 8'hC0;
  localparam logic [7:0] ESC_BYTE       = 8'hDB;
  localparam logic [7:0] END_ESC_BYTE   = 8'hDC;
  localparam logic [7:0] ESC_ESC_BYTE   = 8'hDD;
  localparam logic [7:0] START_STDIO    = 8'h0A;
  localparam logic [7:0] START_CONFIG   = 8'hA9;
  localparam logic [3:0] NIBBLE_IPV4    = 4'h4;
  localparam logic [3:0] NIBBLE_IPV6    = 4'h6;

  localparam int unsigned ADDR_W = 3;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_STDIO    = 4'd1,
    ST_STDIO_E  = 4'd2,
    ST_CFG      = 4'd3,
    ST_CFG_E    = 4'd4,
    ST_NET      = 4'd5,
    ST_NET_E    = 4'd6,
    ST_DISCARD  = 4'd7
  } rx_state_t;

  typedef enum logic [1:0] {
    CH_NONE   = 2'd0,
    CH_STDIO  = 2'd1,
    CH_CONFIG = 2'd2,
    CH_NET    = 2'd3
  } channel_t;

  typedef enum logic {
    REG_STDIO_ENABLE  = 1'b0,
    REG_CONFIG_ENABLE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic stdio_enable;
    logic config_enable;
  } ctrl_t;

  typedef struct packed {
    channel_t   channel;
    logic [7:0] data;
    logic       data_valid;
    logic       frame_open;
    logic       frame_commit;
    logic       frame_drop;
  } result_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == END_ESC_BYTE) r = END_BYTE;
    else if (b == ESC_ESC_BYTE) r = ESC_BYTE;
    return r;
  endfunction

endpackage

@@ hw/rtl/slipmux_receive_demux_core.sv @@
// Top level of the slipmux receive demultiplexer: state, result register, config port.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | rx_byte, net_room, cfg_room
//  out     | output    | out_valid/out_stall| out_channel, out_data, data_valid,
//          |           |                    | frame_open, frame_commit, frame_drop
//  config  | input     | APB psel/penable   | paddr, pwdata, prdata, pready
//
// One byte per cycle unless the output stalls; the result appears in the cycle
// after its beat is accepted. The single result register sets the figure: a new
// beat is taken whenever it is empty or being emptied in the same cycle.
// Reset returns the receive state to idle and both enables to 1.
// A stall on the output holds the result and stalls the input.
module slipmux_receive_demux_core
  import srd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              net_room,
  input  logic              cfg_room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_channel,
  output logic [7:0]        out_data,
  output logic              data_valid,
  output logic              frame_open,
  output logic              frame_commit,
  output logic              frame_drop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ctrl_t     ctrl;
  rx_state_t state;
  rx_state_t state_next;
  result_t   res_next;
  result_t   res;
  logic      in_accept;

  srd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  srd_decode u_decode (
    .state      (state),
    .rx_byte    (rx_byte),
    .net_room   (net_room),
    .cfg_room   (cfg_room),
    .ctrl       (ctrl),
    .state_next (state_next),
    .res        (res_next)
  );

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) res <= res_next;
  end

  assign out_channel  = res.channel;
  assign out_data     = res.data;
  assign data_valid   = res.data_valid;
  assign frame_open   = res.frame_open;
  assign frame_commit = res.frame_commit;
  assign frame_drop   = res.frame_drop;

endmodule

@@ hw/rtl/srd_regs.sv @@
// Control register file behind the APB-style configuration port.
module srd_regs
  import srd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ctrl_t             ctrl
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.stdio_enable  <= 1'b1;
      ctrl.config_enable <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_STDIO_ENABLE:  ctrl.stdio_enable  <= pwdata[0];
        REG_CONFIG_ENABLE: ctrl.config_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STDIO_ENABLE:  prdata = {31'd0, ctrl.stdio_enable};
      REG_CONFIG_ENABLE: prdata = {31'd0, ctrl.config_enable};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/srd_decode.sv @@
// Receive state machine: next state and result for one received byte.
module srd_decode
  import srd_pkg::*;
(
  input  rx_state_t  state,
  input  logic [7:0] rx_byte,
  input  logic       net_room,
  input  logic       cfg_room,
  input  ctrl_t      ctrl,
  output rx_state_t  state_next,
  output result_t    res
);

  logic       is_net_start;
  logic [7:0] dec_byte;

  assign is_net_start = (rx_byte[7:4] == NIBBLE_IPV4) || (rx_byte[7:4] == NIBBLE_IPV6);
  assign dec_byte = ((state == ST_STDIO_E) || (state == ST_CFG_E) || (state == ST_NET_E))
                    ? unescape(rx_byte) : rx_byte;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rx_byte == START_STDIO) begin
          state_next = ST_STDIO;
        end else if (rx_byte == START_CONFIG) begin
          state_next = (!ctrl.config_enable || cfg_room) ? ST_CFG : ST_DISCARD;
        end else if (is_net_start) begin
          state_next = net_room ? ST_NET : ST_DISCARD;
        end else if (rx_byte != END_BYTE) begin
          state_next = ST_DISCARD;
        end
      end
      ST_STDIO: begin
        if (rx_byte == ESC_BYTE) state_next = ST_STDIO_E;
        else if (rx_byte == END_BYTE) state_next = ST_IDLE;
        else state_next = ST_STDIO;
      end
      ST_STDIO_E: state_next = ST_STDIO;
      ST_CFG: begin
        if (rx_byte == ESC_BYTE) state_next = ST_CFG_E;
        else if (rx_byte == END_BYTE) state_next = ST_IDLE;
        else state_next = (!ctrl.config_enable || cfg_room) ? ST_CFG : ST_DISCARD;
      end
      ST_CFG_E: state_next = (!ctrl.config_enable || cfg_room) ? ST_CFG : ST_DISCARD;
      ST_NET: begin
        if (rx_byte == ESC_BYTE) state_next = ST_NET_E;
        else if (rx_byte == END_BYTE) state_next = ST_IDLE;
        else state_next = net_room ? ST_NET : ST_DISCARD;
      end
      ST_NET_E: state_next = net_room ? ST_NET : ST_DISCARD;
      default: state_next = (rx_byte == END_BYTE) ? ST_IDLE : ST_DISCARD;
    endcase
  end

  always_comb begin
    res = '0;
    case (state)
      ST_IDLE: begin
        if (rx_byte == START_CONFIG && ctrl.config_enable) begin
          res.channel    = CH_CONFIG;
          res.frame_open = cfg_room;
          res.frame_drop = !cfg_room;
        end else if (rx_byte != START_STDIO && rx_byte != START_CONFIG && is_net_start) begin
          res.channel    = CH_NET;
          res.frame_open = net_room;
          res.data_valid = net_room;
          res.data       = net_room ? rx_byte : 8'd0;
          res.frame_drop = !net_room;
        end
      end
      ST_STDIO, ST_STDIO_E: begin
        if (!(state == ST_STDIO && (rx_byte == ESC_BYTE || rx_byte == END_BYTE))
            && ctrl.stdio_enable) begin
          res.channel    = CH_STDIO;
          res.data_valid = 1'b1;
          res.data       = dec_byte;
        end
      end
      ST_CFG, ST_CFG_E: begin
        if (state == ST_CFG && rx_byte == ESC_BYTE) begin
          res = '0;
        end else if (state == ST_CFG && rx_byte == END_BYTE) begin
          if (ctrl.config_enable) begin
            res.channel      = CH_CONFIG;
            res.frame_commit = 1'b1;
          end
        end else if (ctrl.config_enable) begin
          res.channel    = CH_CONFIG;
          res.data_valid = cfg_room;
          res.data       = cfg_room ? dec_byte : 8'd0;
          res.frame_drop = !cfg_room;
        end
      end
      ST_NET, ST_NET_E: begin
        if (state == ST_NET && rx_byte == ESC_BYTE) begin
          res = '0;
        end else if (state == ST_NET && rx_byte == END_BYTE) begin
          res.channel      = CH_NET;
          res.frame_commit = 1'b1;
        end else begin
          res.channel    = CH_NET;
          res.data_valid = net_room;
          res.data       = net_room ? dec_byte : 8'd0;
          res.frame_drop = !net_room;
        end
      end
      default: res = '0;
    endcase
  end

endmodule
